// File: rtl/fbfa_pkg.sv
package fbfa_pkg;

  // table geometry
  localparam int unsigned NUM_BLOCKS = 16;
  localparam int unsigned BLK_W      = 4;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CNT_W      = 5;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // fit modes
  localparam logic MODE_FIRST = 1'b0;
  localparam logic MODE_BEST  = 1'b1;

  // configuration register indexes
  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(NUM_BLOCKS);

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } fbfa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_end;
  } fbfa_status_t;

endpackage

// File: rtl/first_best_fit_allocator.sv
// First-fit / best-fit partition allocator. Pulse start_i while busy_o is low to
// transfer one item: a load writes the free size of block_index_i, an allocate
// searches the first block_count blocks for size_value_i. Each item gives one
// result, marked by done_o for a single cycle; the receiver cannot stall it, so
// capture it when it shows. A load reports the cycle after it is taken and the
// block stays free to take an item in that same cycle. An allocate compares one
// block per cycle and holds busy_o through its scan and finish states; it reports
// in the cycle busy_o falls. First fit stops at the first block that fits. Blocks
// searched must have been loaded since reset. Write configuration only while idle.
module first_best_fit_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [fbfa_pkg::BLK_W-1:0]    block_index_i,
  input  logic [fbfa_pkg::SIZE_W-1:0]   size_value_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [fbfa_pkg::CNT_W-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic                          allocated_o,
  output logic [fbfa_pkg::BLK_W-1:0]    chosen_block_o,
  output logic [fbfa_pkg::SIZE_W-1:0]   remaining_size_o
);
  import fbfa_pkg::*;

  fbfa_cmd_t    cmd;
  fbfa_status_t status;

  // sequencer
  fbfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  // table, search and result registers
  fbfa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .req_type_i       (req_type_i),
    .block_index_i    (block_index_i),
    .size_value_i     (size_value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .allocated_o      (allocated_o),
    .chosen_block_o   (chosen_block_o),
    .remaining_size_o (remaining_size_o)
  );

  // a result only shows once the block is idle again
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // a taken load reports at once with an empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_type_i == REQ_LOAD)) |=> (done_o && !allocated_o))
    else $error("load transfer gave no empty result");

  // a taken allocate starts the search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_type_i == REQ_ALLOC)) |=> (busy_o && !done_o))
    else $error("allocate transfer did not start a search");

  // a failed or empty result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !allocated_o |-> ((chosen_block_o == '0) && (remaining_size_o == '0)))
    else $error("nonzero fields without an allocation");

  // allocation is only flagged with the strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni) allocated_o |-> done_o)
    else $error("allocated flag outside a result");

endmodule

// File: rtl/fbfa_ctrl.sv
module fbfa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  req_type_i,
  input  fbfa_pkg::fbfa_status_t status_i,
  output fbfa_pkg::fbfa_cmd_t   cmd_o,
  output logic                  busy_o
);
  import fbfa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.scan    = 1'b0;
    cmd_o.finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = start_i;
        if (start_i && (req_type_i == REQ_ALLOC)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_end) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: rtl/fbfa_dp.sv
module fbfa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbfa_pkg::fbfa_cmd_t           cmd_i,
  output fbfa_pkg::fbfa_status_t        status_o,
  input  logic                          req_type_i,
  input  logic [fbfa_pkg::BLK_W-1:0]    block_index_i,
  input  logic [fbfa_pkg::SIZE_W-1:0]   size_value_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [fbfa_pkg::CNT_W-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic                          allocated_o,
  output logic [fbfa_pkg::BLK_W-1:0]    chosen_block_o,
  output logic [fbfa_pkg::SIZE_W-1:0]   remaining_size_o
);
  import fbfa_pkg::*;

  logic [SIZE_W-1:0] free_q [NUM_BLOCKS];
  logic              fit_mode_q;
  logic [CNT_W-1:0]  block_count_q;
  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              found_q;
  logic [BLK_W-1:0]  best_idx_q;
  logic [SIZE_W-1:0] best_val_q;
  logic              done_q;
  logic              allocated_q;
  logic [BLK_W-1:0]  chosen_q;
  logic [SIZE_W-1:0] remain_q;

  logic [CNT_W-1:0]  used_blocks;
  logic [SIZE_W-1:0] rd_val;
  logic              fits;
  logic              take;
  logic [SIZE_W-1:0] new_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= MODE_FIRST;
      block_count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_FIT_MODE) begin
        fit_mode_q <= cfg_wdata_i[0];
      end else begin
        block_count_q <= cfg_wdata_i;
      end
    end
  end

  // scan compare, one block per cycle
  assign used_blocks = (block_count_q > BLOCK_COUNT_RST) ? BLOCK_COUNT_RST : block_count_q;
  assign rd_val      = free_q[cnt_q[BLK_W-1:0]];
  assign fits        = (size_q <= rd_val);
  assign take        = cmd_i.scan && fits && (!found_q || (rd_val < best_val_q));
  assign new_free    = best_val_q - size_q;

  assign status_o.scan_end = (cnt_q >= used_blocks) || (found_q && (fit_mode_q == MODE_FIRST));

  // free size table
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (req_type_i == REQ_LOAD)) begin
      free_q[block_index_i] <= size_value_i;
    end else if (cmd_i.finish && found_q) begin
      free_q[best_idx_q] <= new_free;
    end
  end

  // request and search state
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      size_q <= size_value_i;
    end
    if (take) begin
      best_idx_q <= cnt_q[BLK_W-1:0];
      best_val_q <= rd_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.accept) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (fits) begin
        found_q <= 1'b1;
      end
    end
  end

  // result register, one cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      allocated_q <= 1'b0;
      chosen_q    <= '0;
      remain_q    <= '0;
    end else begin
      done_q      <= 1'b0;
      allocated_q <= 1'b0;
      chosen_q    <= '0;
      remain_q    <= '0;
      if (cmd_i.accept && (req_type_i == REQ_LOAD)) begin
        done_q <= 1'b1;
      end else if (cmd_i.finish) begin
        done_q <= 1'b1;
        if (found_q) begin
          allocated_q <= 1'b1;
          chosen_q    <= best_idx_q;
          remain_q    <= new_free;
        end
      end
    end
  end

  assign done_o           = done_q;
  assign allocated_o      = allocated_q;
  assign chosen_block_o   = chosen_q;
  assign remaining_size_o = remain_q;

endmodule
